>>> rtl/cbe_pkg.sv
// Shared types and constants for the cubic Bezier easing core.
// No dependencies; imported by cbe_bez_eval and cubic_bezier_easing_core.
`timescale 1ns / 1ps
`default_nettype none

package cbe_pkg;

	// Configuration register index
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X1 = 2'd0,
		REG_Y1 = 2'd1,
		REG_X2 = 2'd2,
		REG_Y2 = 2'd3
	} cbe_reg_t;

	// Multiply ranks in one curve evaluation; one more stage combines and compares.
	localparam int BEZ_STAGES = 3;

	// Stage load enables handed to a curve evaluator
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} cbe_ld_t;

endpackage

`default_nettype wire

>>> rtl/cbe_if.sv
// Stream interfaces for the easing core: progress words in, eased words out.
// Standalone; width set by the instantiating level.
`timescale 1ns / 1ps
`default_nettype none

interface cbe_progress_if #(parameter int W = 17) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] progress;

	modport source (output valid, output progress, input ready);
	modport sink   (input valid, input progress, output ready);
endinterface

interface cbe_eased_if #(parameter int W = 17) ();
	logic         valid;
	logic         ready;
	logic [W-1:0] eased;

	modport source (output valid, output eased, input ready);
	modport sink   (input valid, input eased, output ready);
endinterface

`default_nettype wire

>>> rtl/cbe_bez_eval.sv
// Three-rank pipelined cubic Bezier term evaluator (weights and control products).
// Depends on cbe_pkg (cbe_ld_t).
`timescale 1ns / 1ps
`default_nettype none

module cbe_bez_eval import cbe_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                    clk,
	input  wire cbe_ld_t                 ld,
	input  wire logic [FRAC_BITS:0]      u,
	input  wire logic [FRAC_BITS:0]      p1,
	input  wire logic [FRAC_BITS:0]      p2,
	output logic      [2*FRAC_BITS+1:0]  m0,
	output logic      [2*FRAC_BITS+1:0]  m1,
	output logic      [FRAC_BITS:0]      w2
);

	localparam int W = FRAC_BITS + 1;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

	logic [W-1:0]   inv;
	logic [2*W-1:0] pa, pb, pc;
	logic [2*W-1:0] q0, q1, q2;

	logic [W-1:0]   a_s1, b_s1, c_s1, u_s1;
	logic [W-1:0]   w0_s2, w1_s2, w2_s2;
	logic [2*W-1:0] m0_s3, m1_s3;
	logic [W-1:0]   w2_s3;

	// rank 1: (1-u)^2, (1-u)u, u^2
	assign inv = ONE - u;
	assign pa  = inv * inv;
	assign pb  = inv * u;
	assign pc  = u * u;

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			a_s1 <= pa[FRAC_BITS +: W];
			b_s1 <= pb[FRAC_BITS +: W];
			c_s1 <= pc[FRAC_BITS +: W];
			u_s1 <= u;
		end
	end

	// rank 2: cubic weights
	assign q0 = a_s1 * u_s1;
	assign q1 = b_s1 * u_s1;
	assign q2 = c_s1 * u_s1;

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			w0_s2 <= q0[FRAC_BITS +: W];
			w1_s2 <= q1[FRAC_BITS +: W];
			w2_s2 <= q2[FRAC_BITS +: W];
		end
	end

	// rank 3: weight times control coordinate, factor 3 applied by consumer
	always_ff @(posedge clk) begin
		if (ld.s3) begin
			m0_s3 <= w0_s2 * p1;
			m1_s3 <= w1_s2 * p2;
			w2_s3 <= w2_s2;
		end
	end

	assign m0 = m0_s3;
	assign m1 = m1_s3;
	assign w2 = w2_s3;

endmodule

`default_nettype wire

>>> rtl/cubic_bezier_easing_core.sv
// Cubic Bezier easing core: control registers, bisection pipeline, output stage.
// Depends on cbe_pkg, cbe_if (cbe_progress_if, cbe_eased_if) and cbe_bez_eval.
//
//   port      dir     width         notes
//   feed      sink    FRAC_BITS+1   progress word, valid/ready
//   result    source  FRAC_BITS+1   eased word, valid/ready
//   wr_*      in      2 / F+1       register write: wr_en, wr_index, wr_data
//
// One word per cycle unless result stalls with every stage full. Each
// bisection step is three multiply ranks plus a combine/compare/update stage,
// and the final curve y uses the same four stages ending in the output register.
// arst_n clears the valid bits and loads the control point defaults.
// Stages hold independently: a bubble ahead of a stalled word is filled, so
// words keep entering until every stage holds a word.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bezier_easing_core import cbe_pkg::*; #(
	parameter int BISECT_STEPS = 10,
	parameter int FRAC_BITS    = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	cbe_progress_if.sink              feed,
	cbe_eased_if.source               result,
	input  wire logic                 wr_en,
	input  wire logic [CFG_IDX_W-1:0] wr_index,
	input  wire logic [FRAC_BITS:0]   wr_data
);

	localparam int W    = FRAC_BITS + 1;
	localparam int SPS  = BEZ_STAGES + 1;
	localparam int NST  = SPS * (BISECT_STEPS + 1);
	localparam int LAST = NST - 1;
	localparam int UPD  = SPS * BISECT_STEPS - 1;
	localparam int XW   = FRAC_BITS + 6;

	localparam logic [W-1:0]    ONE   = W'(1) << FRAC_BITS;
	localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
	localparam logic [W-1:0]    X1_RST = W'((ONE_L * 16 + 50) / 100);
	localparam logic [W-1:0]    X2_RST = W'((ONE_L * 30 + 50) / 100);

	logic [W-1:0] x1_q, y1_q, x2_q, y2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= X1_RST;
			y1_q <= ONE;
			x2_q <= X2_RST;
			y2_q <= ONE;
		end else if (wr_en) begin
			case (cbe_reg_t'(wr_index))
				REG_X1:  x1_q <= wr_data;
				REG_Y1:  y1_q <= wr_data;
				REG_X2:  x2_q <= wr_data;
				REG_Y2:  y2_q <= wr_data;
				default: ;
			endcase
		end
	end

	// ---- valid bits and per-stage load ----
	logic [NST-1:0] vld_s;
	logic [NST-1:0] ld;

	for (genvar g = 0; g < NST; g++) begin : g_ld
		// stage loads unless it and every stage after it is full and the sink stalls
		assign ld[g] = result.ready | ~(&vld_s[NST-1:g]);
	end

	assign feed.ready = ld[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (ld[0])
				vld_s[0] <= feed.valid;
			for (int g = 1; g < NST; g++) begin
				if (ld[g])
					vld_s[g] <= vld_s[g-1];
			end
		end
	end

	// ---- per-stage word context ----
	logic [W-1:0] t_s  [NST-1];
	logic [W-1:0] lo_s [NST-1];
	logic [W-1:0] hi_s [NST-1];
	logic [W-1:0] u_s  [NST-1];
	logic [W-1:0] eased_q;

	for (genvar k = 0; k <= BISECT_STEPS; k++) begin : g_step
		localparam int BASE = SPS * k;

		logic [W-1:0]    u_in, p1, p2;
		logic [2*W-1:0]  m0, m1;
		logic [W-1:0]    w2;
		logic [2*W:0]    msum;
		logic [2*W+2:0]  m3;
		logic [XW-1:0]   xv;
		cbe_ld_t         bld;

		if (k == 0) begin : g_first
			assign u_in = feed.progress;
		end else begin : g_next
			assign u_in = u_s[BASE-1];
		end

		assign p1 = (k < BISECT_STEPS) ? x1_q : y1_q;
		assign p2 = (k < BISECT_STEPS) ? x2_q : y2_q;

		assign bld.s1 = ld[BASE];
		assign bld.s2 = ld[BASE+1];
		assign bld.s3 = ld[BASE+2];

		cbe_bez_eval #(.FRAC_BITS(FRAC_BITS)) u_bez (
			.clk (clk),
			.ld  (bld),
			.u   (u_in),
			.p1  (p1),
			.p2  (p2),
			.m0  (m0),
			.m1  (m1),
			.w2  (w2)
		);

		// ((3*m0 + 3*m1) >> F) + w2
		assign msum = {1'b0, m0} + {1'b0, m1};
		assign m3   = {2'b00, msum} + {1'b0, msum, 1'b0};
		assign xv   = XW'({1'b0, m3[2*W+2:FRAC_BITS]}) + XW'(w2);

		// context rides along the three multiply ranks
		for (genvar j = 0; j < BEZ_STAGES; j++) begin : g_pass
			localparam int G = BASE + j;
			if (G == 0) begin : g_entry
				always_ff @(posedge clk) begin
					if (ld[G]) begin
						t_s[G]  <= feed.progress;
						lo_s[G] <= '0;
						hi_s[G] <= ONE;
						u_s[G]  <= feed.progress;
					end
				end
			end else begin : g_copy
				always_ff @(posedge clk) begin
					if (ld[G]) begin
						t_s[G]  <= t_s[G-1];
						lo_s[G] <= lo_s[G-1];
						hi_s[G] <= hi_s[G-1];
						u_s[G]  <= u_s[G-1];
					end
				end
			end
		end

		if (k < BISECT_STEPS) begin : g_upd
			localparam int G = BASE + BEZ_STAGES;
			logic         below;
			logic [W-1:0] lo_n, hi_n;
			logic [W:0]   mid;

			assign below = xv < XW'(t_s[G-1]);
			assign lo_n  = below ? u_s[G-1] : lo_s[G-1];
			assign hi_n  = below ? hi_s[G-1] : u_s[G-1];
			assign mid   = {1'b0, lo_n} + {1'b0, hi_n};

			always_ff @(posedge clk) begin
				if (ld[G]) begin
					t_s[G]  <= t_s[G-1];
					lo_s[G] <= lo_n;
					hi_s[G] <= hi_n;
					u_s[G]  <= mid[W:1];
				end
			end
		end else begin : g_out
			logic [W-1:0] eased_n;

			always_comb begin
				if (t_s[LAST-1] == '0)
					eased_n = '0;
				else if (t_s[LAST-1] >= ONE)
					eased_n = ONE;
				else if (xv > XW'(ONE))
					eased_n = ONE;
				else
					eased_n = xv[W-1:0];
			end

			always_ff @(posedge clk) begin
				if (ld[LAST])
					eased_q <= eased_n;
			end
		end
	end

	assign result.valid = vld_s[LAST];
	assign result.eased = eased_q;

	// ---- assertions ----
	a_eased_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.eased <= ONE)
		else $error("eased word above one");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!feed.ready |-> (&vld_s) && !result.ready)
		else $error("input blocked with a free stage");

	a_bracket: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[UPD] && t_s[UPD] != '0 && t_s[UPD] < ONE)
		|-> (lo_s[UPD] <= hi_s[UPD] && u_s[UPD] >= lo_s[UPD] && u_s[UPD] < ONE))
		else $error("bisection bracket broken");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[LAST-1] && result.ready) |=> result.valid)
		else $error("word lost at output stage");

endmodule

`default_nettype wire

>>> tb/tb.sv
// Testbench for cubic_bezier_easing_core: drives progress words, predicts eased words.
// Depends on cbe_pkg, cbe_if and the core RTL; stands alone otherwise.
`timescale 1ns / 1ps

module tb;
	import cbe_pkg::*;

	localparam int          FRAC      = 16;
	localparam int          STEPS     = 10;
	localparam int          W         = FRAC + 1;
	localparam logic [63:0] ONE       = 64'd1 << FRAC;
	localparam int          LATENCY   = 4 * STEPS + 4;
	localparam int          MAX_CYCLE = 300000;

	logic          clk;
	logic          arst_n;
	logic          wr_en;
	logic [1:0]    wr_index;
	logic [W-1:0]  wr_data;

	cbe_progress_if #(.W(W)) feed_if ();
	cbe_eased_if    #(.W(W)) eased_if ();

	cubic_bezier_easing_core #(
		.BISECT_STEPS(STEPS),
		.FRAC_BITS(FRAC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed_if),
		.result(eased_if),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// control points as the core should hold them
	logic [W-1:0]  cx1, cy1, cx2, cy2;

	logic [W-1:0]  progress_q[$];
	logic [W-1:0]  eased_q[$];

	bit            idle_on;
	int            send_gap;
	int            stall_left;
	int            n_sent;
	int            n_checked;
	int            n_errors;
	int            n_settings;
	int            cycle_cnt;
	logic          feed_fire;
	logic [W-1:0]  got, want;

	function automatic logic [63:0] curve_at(logic [63:0] u, logic [63:0] p1, logic [63:0] p2);
		logic [63:0] inv, a, b, c, w0, w1, w2;
		inv = ONE - u;
		a   = (inv * inv) >> FRAC;
		b   = (inv * u) >> FRAC;
		c   = (u * u) >> FRAC;
		w0  = (a * u) >> FRAC;
		w1  = (b * u) >> FRAC;
		w2  = (c * u) >> FRAC;
		return ((64'd3 * w0 * p1 + 64'd3 * w1 * p2) >> FRAC) + w2;
	endfunction

	function automatic logic [W-1:0] ease_lookup(logic [W-1:0] t);
		logic [63:0] lo, hi, u, y, tt;
		int          i;
		tt = 64'(t);
		if (tt == 64'd0)
			return '0;
		if (tt >= ONE)
			return ONE[W-1:0];
		lo = 64'd0;
		hi = ONE;
		u  = tt;
		for (i = 0; i < STEPS; i++) begin
			if (curve_at(u, 64'(cx1), 64'(cx2)) < tt)
				lo = u;
			else
				hi = u;
			u = (lo + hi) >> 1;
		end
		y = curve_at(u, 64'(cy1), 64'(cy2));
		if (y > ONE)
			y = ONE;
		return y[W-1:0];
	endfunction

	// mostly interior points, some edges and codes above one
	function automatic logic [W-1:0] rand_progress();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return ONE[W-1:0];
			2: return W'($urandom_range(65537, 131071));
			3: return W'($urandom_range(1, 16));
			4: return W'($urandom_range(65520, 65535));
			default: return W'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [W-1:0] rand_ctrl();
		if ($urandom_range(0, 7) == 0)
			return W'($urandom_range(65537, 131071));
		return W'($urandom_range(0, 65536));
	endfunction

	task automatic write_reg(cbe_reg_t idx, logic [W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		case (idx)
			REG_X1: cx1 = val;
			REG_Y1: cy1 = val;
			REG_X2: cx2 = val;
			REG_Y2: cy2 = val;
			default: ;
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_curve(logic [W-1:0] x1, logic [W-1:0] y1, logic [W-1:0] x2,
			logic [W-1:0] y2);
		write_reg(REG_X1, x1);
		write_reg(REG_Y1, y1);
		write_reg(REG_X2, x2);
		write_reg(REG_Y2, y2);
		n_settings++;
	endtask

	task automatic push_random(int n);
		int i;
		for (i = 0; i < n; i++)
			progress_q.push_back(rand_progress());
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (progress_q.size() != 0 || feed_if.valid || eased_q.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sender: one word held until accepted, random gaps between words while idle_on is set
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_if.valid    <= 1'b0;
			feed_if.progress <= '0;
			send_gap         <= 0;
		end else begin
			feed_fire = feed_if.valid && feed_if.ready;
			if (feed_fire) begin
				eased_q.push_back(ease_lookup(feed_if.progress));
				n_sent++;
			end
			if (feed_if.valid && !feed_fire) begin
				// hold the word
			end else if (send_gap > 0) begin
				send_gap      <= send_gap - 1;
				feed_if.valid <= 1'b0;
			end else if (progress_q.size() != 0) begin
				feed_if.valid    <= 1'b1;
				feed_if.progress <= progress_q.pop_front();
				if (idle_on && $urandom_range(0, 9) == 0)
					send_gap <= $urandom_range(1, 15);
			end else begin
				feed_if.valid <= 1'b0;
			end
		end
	end

	// receiver: check each eased word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eased_if.ready <= 1'b0;
			stall_left     <= 0;
		end else begin
			if (eased_if.valid && eased_if.ready) begin
				got = eased_if.eased;
				if (eased_q.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("ERROR: eased word 0x%05h with no prediction pending", got);
				end else begin
					want = eased_q.pop_front();
					n_checked++;
					if (got !== want) begin
						n_errors++;
						if (n_errors <= 10)
							$display("ERROR: eased word %0d: expected 0x%05h got 0x%05h",
								n_checked, want, got);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left     <= stall_left - 1;
				eased_if.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 11) == 0) begin
				stall_left     <= $urandom_range(0, 14);
				eased_if.ready <= 1'b0;
			end else begin
				eased_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= MAX_CYCLE) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_cnt,
				eased_q.size());
			$display("cubic_bezier_easing_core verification failed");
			$finish;
		end
	end

	initial begin
		int i;
		logic [W-1:0] directed[$];
		arst_n           = 1'b0;
		wr_en            = 1'b0;
		wr_index         = '0;
		wr_data          = '0;
		feed_if.valid    = 1'b0;
		feed_if.progress = '0;
		eased_if.ready   = 1'b0;
		idle_on          = 1'b1;
		n_sent           = 0;
		n_checked        = 0;
		n_errors         = 0;
		n_settings       = 1;
		cycle_cnt        = 0;
		cx1              = W'(10486);
		cy1              = ONE[W-1:0];
		cx2              = W'(19661);
		cy2              = ONE[W-1:0];
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset curve: zero, one, codes above one, interior points
		directed = '{17'd0, 17'd1, 17'd2, 17'd100, 17'd10486, 17'd19661, 17'd32768,
			17'h0AAAA, 17'd65534, 17'd65535, 17'd65536, 17'd65537, 17'd98304,
			17'h15555, 17'd131071};
		foreach (directed[i])
			progress_q.push_back(directed[i]);
		wait_drained();

		// extreme control points; y above one saturates
		set_curve('0, '0, '0, '0);
		push_random(30);
		wait_drained();
		set_curve(ONE[W-1:0], ONE[W-1:0], ONE[W-1:0], ONE[W-1:0]);
		push_random(30);
		wait_drained();
		set_curve(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		push_random(30);
		wait_drained();
		set_curve('0, 17'h1FFFF, ONE[W-1:0], '0);
		push_random(30);
		wait_drained();
		set_curve(17'd27525, '0, 17'd38011, ONE[W-1:0]);
		push_random(30);
		wait_drained();

		for (i = 0; i < 5; i++) begin
			set_curve(rand_ctrl(), rand_ctrl(), rand_ctrl(), rand_ctrl());
			if (i == 4)
				idle_on = 1'b0;
			push_random(30);
			// mid-setting pause until the pipeline is empty
			if (i == 2)
				wait_drained();
			push_random(30);
			wait_drained();
		end

		repeat (LATENCY + 20) @(posedge clk);
		if (eased_q.size() != 0) begin
			n_errors += eased_q.size();
			$display("ERROR: %0d predicted eased words never arrived", eased_q.size());
		end
		$display("%0d progress words over %0d control point settings, %0d eased words checked",
			n_sent, n_settings, n_checked);
		$display("%0d mismatches", n_errors);
		if (n_errors == 0)
			$display("cubic_bezier_easing_core verification clean");
		else
			$display("cubic_bezier_easing_core verification failed");
		$finish;
	end

endmodule
